### sv/kclc_pkg.sv
// Package for the keypad code lock controller: phase type, event, item-kind,
// key and register-index codes, reset values and the phase-to-code function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kclc_pkg;

  localparam int MAX_CODE_LEN_D = 16;
  localparam int MODE_LEN_D     = 4;

  typedef enum logic [6:0] {
    PH_SETUP   = 7'b0000001,
    PH_MODE    = 7'b0000010,
    PH_PASS    = 7'b0000100,
    PH_OPEN    = 7'b0001000,
    PH_LOCKOUT = 7'b0010000,
    PH_CHECK   = 7'b0100000,
    PH_NEW     = 7'b1000000
  } phase_t;

  localparam logic [2:0] PHC_SETUP   = 3'd0;
  localparam logic [2:0] PHC_MODE    = 3'd1;
  localparam logic [2:0] PHC_PASS    = 3'd2;
  localparam logic [2:0] PHC_OPEN    = 3'd3;
  localparam logic [2:0] PHC_LOCKOUT = 3'd4;
  localparam logic [2:0] PHC_CHECK   = 3'd5;
  localparam logic [2:0] PHC_NEW     = 3'd6;

  localparam logic [3:0] EV_NONE         = 4'd0;
  localparam logic [3:0] EV_CHAR         = 4'd1;
  localparam logic [3:0] EV_SET          = 4'd2;
  localparam logic [3:0] EV_UNLOCK       = 4'd3;
  localparam logic [3:0] EV_DENIED       = 4'd4;
  localparam logic [3:0] EV_LOCKOUT      = 4'd5;
  localparam logic [3:0] EV_LOCKOUT_OVER = 4'd6;
  localparam logic [3:0] EV_LOCKED       = 4'd7;
  localparam logic [3:0] EV_BAD_MODE     = 4'd8;
  localparam logic [3:0] EV_CHANGED      = 4'd9;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;

  localparam logic [7:0] KEY_HASH   = 8'h23;
  localparam logic [7:0] KEY_STAR   = 8'h2A;
  localparam logic [7:0] KEY_IGNORE = 8'h01;

  localparam logic [1:0] CFG_WRONG_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_LOCKOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_OPEN_COMPARE  = 2'd2;
  localparam logic [1:0] CFG_CLOSE_COMPARE = 2'd3;

  localparam logic [3:0]  WRONG_LIMIT_RST   = 4'd5;
  localparam logic [17:0] LOCKOUT_TICKS_RST = 18'd180000;
  localparam logic [9:0]  OPEN_COMPARE_RST  = 10'd75;
  localparam logic [9:0]  CLOSE_COMPARE_RST = 10'd175;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_SETUP:   code = PHC_SETUP;
      PH_MODE:    code = PHC_MODE;
      PH_PASS:    code = PHC_PASS;
      PH_OPEN:    code = PHC_OPEN;
      PH_LOCKOUT: code = PHC_LOCKOUT;
      PH_CHECK:   code = PHC_CHECK;
      PH_NEW:     code = PHC_NEW;
      default:    code = PHC_SETUP;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/keypad_code_lock_controller.sv
// Each result is registered from its input transaction and is valid in the cycle after.
// Throughput: one transaction per cycle; a new input is taken in the cycle
// a pending result is taken, and held off only while a result waits.
// Reset: synchronous, active low; puts the phase in setup, clears counters, timer
// and servo value and loads the register defaults. Code buffers are not cleared.
// Depends on kclc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock_controller #(
  parameter int MAX_CODE_LEN = kclc_pkg::MAX_CODE_LEN_D,
  parameter int MODE_LEN     = kclc_pkg::MODE_LEN_D,
  localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1),
  localparam int MCNT_W = $clog2(MODE_LEN + 1),
  localparam int LEN_W  = (CNT_W > MCNT_W) ? CNT_W : MCNT_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_mode,
  input  wire logic [7:0]       in_key_char,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            out_event_res,
  output logic [2:0]            out_phase,
  output logic [9:0]            out_servo_compare,
  output logic                  out_lamp_on,
  output logic [3:0]            out_wrong_attempts,
  output logic [LEN_W-1:0]      out_entry_length,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [17:0]      cfg_data
);

  localparam int EIDX_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int MIDX_W = $clog2(MODE_LEN);

  logic [3:0]  wrong_limit_r;
  logic [17:0] lockout_ticks_r;
  logic [9:0]  open_compare_r;
  logic [9:0]  close_compare_r;

  kclc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]        entry_buf_r [MAX_CODE_LEN];
  logic [7:0]        stored_r    [MAX_CODE_LEN];
  logic [7:0]        mode_buf_r  [MODE_LEN];
  logic [7:0]        entry_eff   [MAX_CODE_LEN];
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0]  stored_count_r, stored_count_nxt;
  logic [MCNT_W-1:0] mode_count_r, mode_count_nxt;
  logic [3:0]        miss_r, miss_nxt, miss_inc;
  logic [17:0]       timer_r, timer_nxt;
  logic [9:0]        servo_r, servo_nxt;
  logic [3:0]        ev_nxt;

  logic             out_valid_r;
  logic [3:0]       event_r;
  logic [2:0]       phase_out_r;
  logic [LEN_W-1:0] len_r;

  logic             acc;
  logic             key_is_hash;
  logic [CNT_W-1:0] cnt_eff;
  logic             entry_full;
  logic             code_ok;
  logic             star1, star3;
  logic             entry_wr, mode_wr, store_wr;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;

  assign key_is_hash = (in_key_char == kclc_pkg::KEY_HASH);
  assign cnt_eff     = entry_count_r + CNT_W'(!key_is_hash);
  assign entry_full  = (cnt_eff == CNT_W'(MAX_CODE_LEN));

  assign star1 = (mode_count_r == MCNT_W'(1)) && (mode_buf_r[0] == kclc_pkg::KEY_STAR);
  assign star3 = (mode_count_r == MCNT_W'(3)) && (mode_buf_r[0] == kclc_pkg::KEY_STAR) &&
                 (mode_buf_r[1] == kclc_pkg::KEY_STAR) && (mode_buf_r[2] == kclc_pkg::KEY_STAR);

  assign miss_inc = (miss_r == 4'hF) ? miss_r : miss_r + 4'd1;

  always_comb begin
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      entry_eff[i] = (!key_is_hash && entry_count_r == CNT_W'(i)) ? in_key_char
                                                                   : entry_buf_r[i];
    end
  end

  always_comb begin
    code_ok = (cnt_eff == stored_count_r);
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      if (CNT_W'(i) < cnt_eff && entry_eff[i] != stored_r[i]) begin
        code_ok = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    entry_count_nxt  = entry_count_r;
    stored_count_nxt = stored_count_r;
    mode_count_nxt   = mode_count_r;
    miss_nxt         = miss_r;
    timer_nxt        = timer_r;
    servo_nxt        = servo_r;
    ev_nxt           = kclc_pkg::EV_NONE;
    entry_wr         = 1'b0;
    mode_wr          = 1'b0;
    store_wr         = 1'b0;
    case (in_mode)
      kclc_pkg::KIND_KEY: begin
        if (in_key_char != kclc_pkg::KEY_IGNORE) begin
          case (phase_r)
            kclc_pkg::PH_MODE: begin
              if (key_is_hash) begin
                if (star1) begin
                  phase_nxt       = kclc_pkg::PH_PASS;
                  entry_count_nxt = '0;
                end else if (star3) begin
                  phase_nxt       = kclc_pkg::PH_CHECK;
                  entry_count_nxt = '0;
                end else begin
                  ev_nxt = kclc_pkg::EV_BAD_MODE;
                end
                mode_count_nxt = '0;
              end else begin
                mode_wr        = 1'b1;
                mode_count_nxt = mode_count_r + MCNT_W'(1);
                if (mode_count_nxt == MCNT_W'(MODE_LEN)) begin
                  ev_nxt         = kclc_pkg::EV_BAD_MODE;
                  mode_count_nxt = '0;
                end else begin
                  ev_nxt = kclc_pkg::EV_CHAR;
                end
              end
            end
            kclc_pkg::PH_SETUP, kclc_pkg::PH_PASS, kclc_pkg::PH_CHECK,
            kclc_pkg::PH_NEW: begin
              entry_wr = !key_is_hash;
              if (key_is_hash || entry_full) begin
                case (phase_r)
                  kclc_pkg::PH_SETUP: begin
                    store_wr         = 1'b1;
                    stored_count_nxt = cnt_eff;
                    phase_nxt        = kclc_pkg::PH_MODE;
                    ev_nxt           = kclc_pkg::EV_SET;
                  end
                  kclc_pkg::PH_PASS: begin
                    if (code_ok) begin
                      servo_nxt = open_compare_r;
                      miss_nxt  = '0;
                      phase_nxt = kclc_pkg::PH_OPEN;
                      ev_nxt    = kclc_pkg::EV_UNLOCK;
                    end else begin
                      miss_nxt = miss_inc;
                      if (miss_inc >= wrong_limit_r) begin
                        timer_nxt = lockout_ticks_r;
                        phase_nxt = kclc_pkg::PH_LOCKOUT;
                        ev_nxt    = kclc_pkg::EV_LOCKOUT;
                      end else begin
                        ev_nxt = kclc_pkg::EV_DENIED;
                      end
                    end
                  end
                  kclc_pkg::PH_CHECK: begin
                    if (code_ok) begin
                      phase_nxt = kclc_pkg::PH_NEW;
                    end else begin
                      phase_nxt = kclc_pkg::PH_MODE;
                      ev_nxt    = kclc_pkg::EV_DENIED;
                    end
                  end
                  default: begin
                    store_wr         = 1'b1;
                    stored_count_nxt = cnt_eff;
                    phase_nxt        = kclc_pkg::PH_MODE;
                    ev_nxt           = kclc_pkg::EV_CHANGED;
                  end
                endcase
                entry_count_nxt = '0;
                mode_count_nxt  = '0;
              end else begin
                entry_count_nxt = cnt_eff;
                ev_nxt          = kclc_pkg::EV_CHAR;
              end
            end
            default: ;
          endcase
        end
      end
      kclc_pkg::KIND_TICK: begin
        if (phase_r == kclc_pkg::PH_LOCKOUT) begin
          if (timer_r <= 18'd1) begin
            timer_nxt       = '0;
            miss_nxt        = '0;
            entry_count_nxt = '0;
            phase_nxt       = kclc_pkg::PH_PASS;
            ev_nxt          = kclc_pkg::EV_LOCKOUT_OVER;
          end else begin
            timer_nxt = timer_r - 18'd1;
          end
        end
      end
      kclc_pkg::KIND_BUTTON: begin
        if (phase_r == kclc_pkg::PH_OPEN) begin
          servo_nxt      = close_compare_r;
          phase_nxt      = kclc_pkg::PH_MODE;
          mode_count_nxt = '0;
          ev_nxt         = kclc_pkg::EV_LOCKED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrong_limit_r   <= kclc_pkg::WRONG_LIMIT_RST;
      lockout_ticks_r <= kclc_pkg::LOCKOUT_TICKS_RST;
      open_compare_r  <= kclc_pkg::OPEN_COMPARE_RST;
      close_compare_r <= kclc_pkg::CLOSE_COMPARE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kclc_pkg::CFG_WRONG_LIMIT:   wrong_limit_r   <= cfg_data[3:0];
        kclc_pkg::CFG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_data;
        kclc_pkg::CFG_OPEN_COMPARE:  open_compare_r  <= cfg_data[9:0];
        kclc_pkg::CFG_CLOSE_COMPARE: close_compare_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= kclc_pkg::PH_SETUP;
      entry_count_r  <= '0;
      stored_count_r <= '0;
      mode_count_r   <= '0;
      miss_r         <= '0;
      timer_r        <= '0;
      servo_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (acc) begin
        phase_r        <= phase_nxt;
        entry_count_r  <= entry_count_nxt;
        stored_count_r <= stored_count_nxt;
        mode_count_r   <= mode_count_nxt;
        miss_r         <= miss_nxt;
        timer_r        <= timer_nxt;
        servo_r        <= servo_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (entry_wr && !entry_full) begin
        entry_buf_r[entry_count_r[EIDX_W-1:0]] <= in_key_char;
      end
      if (mode_wr) begin
        mode_buf_r[mode_count_r[MIDX_W-1:0]] <= in_key_char;
      end
      if (store_wr) begin
        for (int i = 0; i < MAX_CODE_LEN; i++) begin
          stored_r[i] <= entry_eff[i];
        end
      end
      event_r     <= ev_nxt;
      phase_out_r <= kclc_pkg::phase_code(phase_nxt);
      len_r       <= (phase_nxt == kclc_pkg::PH_MODE) ? LEN_W'(mode_count_nxt)
                                                      : LEN_W'(entry_count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = event_r;
  assign out_phase          = phase_out_r;
  assign out_servo_compare  = servo_r;
  assign out_lamp_on        = (phase_r == kclc_pkg::PH_OPEN);
  assign out_wrong_attempts = miss_r;
  assign out_entry_length   = len_r;

endmodule

`default_nettype wire

### sv/kclc_checker.sv
// Port-level checker for the keypad code lock controller, with its bind.
// Depends on kclc_pkg and keypad_code_lock_controller.
`timescale 1ns / 1ps
`default_nettype none

module kclc_checker #(
  parameter int MAX_CODE_LEN = kclc_pkg::MAX_CODE_LEN_D,
  parameter int MODE_LEN     = kclc_pkg::MODE_LEN_D,
  localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1),
  localparam int MCNT_W = $clog2(MODE_LEN + 1),
  localparam int LEN_W  = (CNT_W > MCNT_W) ? CNT_W : MCNT_W
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [3:0]       out_event_res,
  input wire logic [2:0]       out_phase,
  input wire logic [9:0]       out_servo_compare,
  input wire logic             out_lamp_on,
  input wire logic [3:0]       out_wrong_attempts,
  input wire logic [LEN_W-1:0] out_entry_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) &&
      $stable(out_phase) && $stable(out_servo_compare) && $stable(out_entry_length))
    else $error("result changed while stalled");

  a_lamp_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lamp_on == (out_phase == kclc_pkg::PHC_OPEN)))
    else $error("lamp disagrees with phase");

  a_unlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == kclc_pkg::EV_UNLOCK |->
      out_lamp_on && out_wrong_attempts == 4'd0)
    else $error("unlock without lamp or with misses left");

  a_lockout_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == kclc_pkg::EV_LOCKOUT_OVER |->
      out_phase == kclc_pkg::PHC_PASS && out_wrong_attempts == 4'd0 &&
      out_entry_length == '0)
    else $error("lockout end state wrong");

  a_mode_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == kclc_pkg::PHC_MODE |-> out_entry_length < LEN_W'(MODE_LEN))
    else $error("mode entry overran");

endmodule

bind keypad_code_lock_controller kclc_checker #(
  .MAX_CODE_LEN(MAX_CODE_LEN),
  .MODE_LEN(MODE_LEN)
) u_kclc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_event_res(out_event_res),
  .out_phase(out_phase),
  .out_servo_compare(out_servo_compare),
  .out_lamp_on(out_lamp_on),
  .out_wrong_attempts(out_wrong_attempts),
  .out_entry_length(out_entry_length)
);

`default_nettype wire
